FILE: rtl/aet_pkg.sv
// Package for the arithmetic expression tokenizer: types, token codes, character constants.
package aet_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_VALUE_BITS  = 32;
  localparam int DEF_LINE_BITS   = 24;
  localparam int DEF_QUEUE_DEPTH = 4;

  // Token kinds
  localparam logic [2:0] TK_EOF   = 3'd0;
  localparam logic [2:0] TK_PLUS  = 3'd1;
  localparam logic [2:0] TK_MINUS = 3'd2;
  localparam logic [2:0] TK_TIMES = 3'd3;
  localparam logic [2:0] TK_DIV   = 3'd4;
  localparam logic [2:0] TK_INT   = 3'd5;
  localparam logic [2:0] TK_ERR   = 3'd6;

  // Characters recognized by the scanner
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FF    = 8'h0C;

  // Input request: one source byte or the end mark
  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } aet_in_t;

  // One emitted token
  typedef struct packed {
    logic [2:0]  token_kind;
    logic [31:0] literal_value;
    logic [7:0]  bad_char;
    logic [23:0] line_number;
    logic        last_of_run;
  } aet_tok_t;

  // Queue entry: all tokens caused by one request
  typedef struct packed {
    logic     two;
    aet_tok_t tok0;
    aet_tok_t tok1;
  } aet_entry_t;

endpackage

FILE: rtl/aet_front.sv
// Front end: classifies each byte, builds literals, counts lines, forms queue entries.
module aet_front
  import aet_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int LINE_BITS  = DEF_LINE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_data,
  input  logic        req_fire,
  input  aet_in_t     req,
  output logic        push,
  output aet_entry_t  entry
);

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  num_r, num_nxt;
  logic [LINE_BITS-1:0]  line_r, line_nxt;

  logic [7:0]            b;
  logic                  is_digit, is_ws;
  logic [VALUE_BITS-1:0] digit;
  logic [VALUE_BITS+3:0] prod;
  logic                  have_term;
  aet_tok_t              int_tok, term_tok;

  assign b        = req.source_byte;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_ws    = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
                    (b == CH_CR) || (b == CH_FF);
  assign digit    = VALUE_BITS'(b - CH_ZERO);

  // acc*10 + digit, wide enough to see overflow
  assign prod = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0} + {4'b0000, digit};

  always_comb begin
    acc_nxt   = acc_r;
    num_nxt   = num_r;
    line_nxt  = line_r;
    push      = 1'b0;
    have_term = 1'b0;
    entry     = '0;

    if (!req.end_of_input && b == CH_LF) begin
      line_nxt = line_r + LINE_BITS'(1);
    end

    // Literal token and the token for the terminating byte
    int_tok               = '0;
    int_tok.token_kind    = TK_INT;
    int_tok.literal_value = 32'(acc_r);
    int_tok.line_number   = 24'(line_nxt);
    term_tok              = '0;
    term_tok.line_number  = 24'(line_nxt);
    term_tok.last_of_run  = 1'b1;

    if (req.end_of_input) begin
      term_tok.token_kind = TK_EOF;
      have_term           = 1'b1;
    end else if (is_ws || is_digit) begin
      have_term = 1'b0;
    end else begin
      have_term = 1'b1;
      case (b)
        CH_PLUS:  term_tok.token_kind = TK_PLUS;
        CH_MINUS: term_tok.token_kind = TK_MINUS;
        CH_STAR:  term_tok.token_kind = TK_TIMES;
        CH_SLASH: term_tok.token_kind = TK_DIV;
        default: begin
          term_tok.token_kind = TK_ERR;
          term_tok.bad_char   = b;
        end
      endcase
    end

    if (req_fire) begin
      if (num_r && is_digit && !req.end_of_input) begin
        // Digit inside a literal: accumulate with saturation
        acc_nxt = (prod[VALUE_BITS+3:VALUE_BITS] != 4'd0) ? VALUE_MAX
                                                           : prod[VALUE_BITS-1:0];
      end else begin
        if (num_r) begin
          push = 1'b1;
          entry.tok0 = int_tok;
          if (have_term) begin
            entry.two  = 1'b1;
            entry.tok1 = term_tok;
          end else begin
            entry.tok0.last_of_run = 1'b1;
          end
        end else if (have_term) begin
          push       = 1'b1;
          entry.tok0 = term_tok;
        end
        if (!req.end_of_input && is_digit) begin
          acc_nxt = digit;
          num_nxt = 1'b1;
        end else begin
          acc_nxt = '0;
          num_nxt = 1'b0;
        end
      end
    end else begin
      line_nxt = line_r;
    end
  end

  // Scanner state; a config write reloads the line counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      num_r  <= 1'b0;
      line_r <= LINE_BITS'(1);
    end else begin
      acc_r  <= acc_nxt;
      num_r  <= num_nxt;
      line_r <= cfg_we ? LINE_BITS'(cfg_data) : line_nxt;
    end
  end

endmodule

FILE: rtl/aet_queue.sv
// Short entry queue between the front end and the output stage.
module aet_queue
  import aet_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  aet_entry_t wr_entry,
  input  logic       pop,
  output logic       full,
  output logic       rd_valid,
  output aet_entry_t rd_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  aet_entry_t      mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;
  assign full     = (cnt_r == CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_entry = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

endmodule

FILE: rtl/aet_back.sv
// Back end: unpacks queue entries into single tokens on a registered output.
module aet_back
  import aet_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  aet_entry_t q_entry,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output aet_tok_t   out_tok
);

  logic     out_valid_r, out_valid_nxt;
  aet_tok_t out_tok_r;
  logic     phase_r, phase_nxt;
  logic     load;

  assign load      = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_tok   = out_tok_r;

  // The second token of a pair is loaded into the output register once the first has been taken
  always_comb begin
    phase_nxt     = phase_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (q_entry.two && !phase_r) begin
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        q_pop     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok_r <= phase_r ? q_entry.tok1 : q_entry.tok0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

endmodule

FILE: rtl/arith_expression_tokenizer.sv
// Arithmetic expression tokenizer: top level joining front end, queue and output stage.
//
// Takes one source byte (or an end mark) per cycle and emits tokens for + - * /,
// saturated decimal literals, errors and end of input. A new byte is accepted every
// cycle while the entry queue (QUEUE_DEPTH entries) has room. A byte that ends a
// literal and is itself a token yields two tokens, which leave the output register
// one after the other; the queue absorbs these, so the sustained input rate is one
// byte per cycle unless two-token bytes arrive back to back or the output stalls.
// Tokens pass through the entry queue and the output register. A write to cfg_data
// sets the starting line number and reloads the line counter; it is always accepted.
module arith_expression_tokenizer
  import aet_pkg::*;
#(
  parameter int VALUE_BITS  = DEF_VALUE_BITS,
  parameter int LINE_BITS   = DEF_LINE_BITS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  aet_in_t     in_req,
  output logic        out_valid,
  input  logic        out_ready,
  output aet_tok_t    out_tok,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  aet_entry_t push_entry, head_entry;
  logic       push, full, head_valid, pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full;

  // Front end: scan and classify
  aet_front #(
    .VALUE_BITS (VALUE_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .req_fire (in_valid && in_ready),
    .req      (in_req),
    .push     (push),
    .entry    (push_entry)
  );

  // Decoupling queue
  aet_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (push_entry),
    .pop      (pop),
    .full     (full),
    .rd_valid (head_valid),
    .rd_entry (head_entry)
  );

  // Output stage
  aet_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (head_valid),
    .q_entry   (head_entry),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (out_tok)
  );

endmodule
